/* hw/rtl/pci_pkg.sv */
// ----------------------------------------------------------------------------
// Path command interpreter package
// Command letter codes, segment kinds and the small helpers shared by the
// token and segment interfaces and the interpreter itself.
// ----------------------------------------------------------------------------
package pci_pkg;

	localparam int unsigned CoordW  = 32;
	localparam int unsigned LetterW = 8;
	localparam int unsigned CountW  = 3;
	localparam int unsigned StoreN  = 5;

	localparam logic [LetterW-1:0] CMD_NONE = 8'h00;
	localparam logic [LetterW-1:0] CMD_M_ABS = 8'h4D;
	localparam logic [LetterW-1:0] CMD_M_REL = 8'h6D;
	localparam logic [LetterW-1:0] CMD_L_ABS = 8'h4C;
	localparam logic [LetterW-1:0] CMD_L_REL = 8'h6C;
	localparam logic [LetterW-1:0] CMD_H_ABS = 8'h48;
	localparam logic [LetterW-1:0] CMD_H_REL = 8'h68;
	localparam logic [LetterW-1:0] CMD_V_ABS = 8'h56;
	localparam logic [LetterW-1:0] CMD_V_REL = 8'h76;
	localparam logic [LetterW-1:0] CMD_C_ABS = 8'h43;
	localparam logic [LetterW-1:0] CMD_C_REL = 8'h63;
	localparam logic [LetterW-1:0] CMD_Z_ABS = 8'h5A;
	localparam logic [LetterW-1:0] CMD_Z_REL = 8'h7A;
	localparam logic [LetterW-1:0] CMD_LOW_A = 8'h61;
	localparam logic [LetterW-1:0] CMD_LOW_Z = 8'h7A;

	localparam logic TOK_LETTER = 1'b0;
	localparam logic TOK_NUMBER = 1'b1;

	typedef enum logic [1:0] {
		SEG_MOVE  = 2'd0,
		SEG_LINE  = 2'd1,
		SEG_CUBIC = 2'd2,
		SEG_CLOSE = 2'd3
	} seg_kind_t;

	typedef logic signed [CoordW-1:0] coord_t;

	// Number of operands a command letter takes; zero for Z and unknown codes.
	function automatic logic [CountW-1:0] ops_needed(input logic [LetterW-1:0] c);
		logic [CountW-1:0] n;
		case (c)
			CMD_M_ABS, CMD_M_REL, CMD_L_ABS, CMD_L_REL: n = 3'd2;
			CMD_H_ABS, CMD_H_REL, CMD_V_ABS, CMD_V_REL: n = 3'd1;
			CMD_C_ABS, CMD_C_REL:                       n = 3'd6;
			default:                                    n = 3'd0;
		endcase
		return n;
	endfunction

	// Signed add clamped to the 32-bit range.
	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic signed [CoordW:0] s;
		coord_t r;
		s = {a[CoordW-1], a} + {b[CoordW-1], b};
		if (s[CoordW] != s[CoordW-1]) begin
			r = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
		end else begin
			r = s[CoordW-1:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pci_tok_if.sv */
// ----------------------------------------------------------------------------
// Path token channel
// Valid/ready channel carrying one path token word: a letter or a number.
// ----------------------------------------------------------------------------
interface pci_tok_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic [pci_pkg::LetterW-1:0]            letter;
	logic signed [pci_pkg::CoordW-1:0]      value;

	modport source (output valid, kind, letter, value, input ready);
	modport sink   (input valid, kind, letter, value, output ready);
endinterface

/* hw/rtl/pci_seg_if.sv */
// ----------------------------------------------------------------------------
// Path segment channel
// Valid/ready channel carrying one segment word with its control points.
// ----------------------------------------------------------------------------
interface pci_seg_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        seg_kind;
	logic signed [pci_pkg::CoordW-1:0] from_x;
	logic signed [pci_pkg::CoordW-1:0] from_y;
	logic signed [pci_pkg::CoordW-1:0] ctrl1_x;
	logic signed [pci_pkg::CoordW-1:0] ctrl1_y;
	logic signed [pci_pkg::CoordW-1:0] ctrl2_x;
	logic signed [pci_pkg::CoordW-1:0] ctrl2_y;
	logic signed [pci_pkg::CoordW-1:0] end_x;
	logic signed [pci_pkg::CoordW-1:0] end_y;

	modport source (output valid, seg_kind, from_x, from_y, ctrl1_x, ctrl1_y,
		ctrl2_x, ctrl2_y, end_x, end_y, input ready);
	modport sink   (input valid, seg_kind, from_x, from_y, ctrl1_x, ctrl1_y,
		ctrl2_x, ctrl2_y, end_x, end_y, output ready);
endinterface

/* hw/rtl/path_command_interpreter.sv */
// ----------------------------------------------------------------------------
// Path command interpreter
// Turns a stream of path tokens (M L H V C Z, absolute or relative, and
// Q16.16 operands) into move, line, cubic and close segments.
// ----------------------------------------------------------------------------
//  Channel | Dir | Word                          | Handshake
//  tok     | in  | kind, letter, value           | valid/ready
//  seg     | out | seg_kind, from, ctrl1/2, end  | valid/ready
//
// Each token is captured in an input register and interpreted in the next
// cycle, so one token is taken per cycle unless an emitting token stalls.
// A segment is loaded into the output register when the token that completes
// it is processed out of the input register, and is offered downstream from
// there. The output register holds a segment until it is taken; a token that
// would emit stalls only while that register is full and not being drained.
// Reset clears the command, count, skip flag and current and start points;
// the operand buffer is not cleared.
module path_command_interpreter (
	input  logic         clk,
	input  logic         arst_n,
	pci_tok_if.sink      tok,
	pci_seg_if.source    seg
);

	// Input register.
	logic                              valid_s1;
	logic                              kind_s1;
	logic [pci_pkg::LetterW-1:0]       letter_s1;
	pci_pkg::coord_t                   value_s1;

	// Interpreter state.
	logic [pci_pkg::LetterW-1:0]       active_cmd_q;
	logic [pci_pkg::CountW-1:0]        op_cnt_q;
	pci_pkg::coord_t                   op_store_q [pci_pkg::StoreN];
	logic                              skip_q;
	pci_pkg::coord_t                   cur_x_q, cur_y_q, start_x_q, start_y_q;

	// Output register.
	logic                              seg_valid_q;
	pci_pkg::seg_kind_t                seg_kind_q;
	pci_pkg::coord_t                   from_x_q, from_y_q, end_x_q, end_y_q;
	pci_pkg::coord_t                   c1x_q, c1y_q, c2x_q, c2y_q;

	// Combinational interpretation of the token in the input register.
	logic                              emit;
	logic                              do_proc;
	logic                              wr_en;
	logic [pci_pkg::CountW-1:0]        need;
	logic [pci_pkg::CountW-1:0]        cnt_eff;
	logic                              rel;
	logic [pci_pkg::LetterW-1:0]       cmd_d;
	logic [pci_pkg::CountW-1:0]        cnt_d;
	logic                              skip_d;
	pci_pkg::coord_t                   cur_x_d, cur_y_d, start_x_d, start_y_d;
	pci_pkg::seg_kind_t                kind_d;
	pci_pkg::coord_t                   c1x_d, c1y_d, c2x_d, c2y_d, ex_d, ey_d;

	always_comb begin
		need      = pci_pkg::ops_needed(active_cmd_q);
		cnt_eff   = (op_cnt_q >= need) ? '0 : op_cnt_q;
		rel       = (active_cmd_q >= pci_pkg::CMD_LOW_A) &&
			(active_cmd_q <= pci_pkg::CMD_LOW_Z);
		emit      = 1'b0;
		wr_en     = 1'b0;
		cmd_d     = active_cmd_q;
		cnt_d     = op_cnt_q;
		skip_d    = skip_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		start_x_d = start_x_q;
		start_y_d = start_y_q;
		kind_d    = pci_pkg::SEG_LINE;
		c1x_d     = '0;
		c1y_d     = '0;
		c2x_d     = '0;
		c2y_d     = '0;
		ex_d      = cur_x_q;
		ey_d      = cur_y_q;

		if (skip_q) begin
			// The token after an unknown letter is swallowed.
			skip_d = 1'b0;
		end else if (kind_s1 == pci_pkg::TOK_LETTER) begin
			cmd_d = letter_s1;
			cnt_d = '0;
			if (letter_s1 == pci_pkg::CMD_Z_ABS || letter_s1 == pci_pkg::CMD_Z_REL) begin
				emit    = 1'b1;
				kind_d  = pci_pkg::SEG_CLOSE;
				ex_d    = start_x_q;
				ey_d    = start_y_q;
				cur_x_d = start_x_q;
				cur_y_d = start_y_q;
			end else if (pci_pkg::ops_needed(letter_s1) == '0) begin
				skip_d = 1'b1;
			end
		end else if (need != '0) begin
			if (cnt_eff + 3'd1 < need) begin
				wr_en = 1'b1;
				cnt_d = cnt_eff + 3'd1;
			end else begin
				emit  = 1'b1;
				cnt_d = '0;
				case (active_cmd_q)
					pci_pkg::CMD_M_ABS, pci_pkg::CMD_M_REL: begin
						kind_d    = pci_pkg::SEG_MOVE;
						ex_d      = rel ? pci_pkg::sat_add(cur_x_q, op_store_q[0]) : op_store_q[0];
						ey_d      = rel ? pci_pkg::sat_add(cur_y_q, value_s1) : value_s1;
						start_x_d = ex_d;
						start_y_d = ey_d;
						cmd_d     = rel ? pci_pkg::CMD_L_REL : pci_pkg::CMD_L_ABS;
					end
					pci_pkg::CMD_L_ABS, pci_pkg::CMD_L_REL: begin
						ex_d = rel ? pci_pkg::sat_add(cur_x_q, op_store_q[0]) : op_store_q[0];
						ey_d = rel ? pci_pkg::sat_add(cur_y_q, value_s1) : value_s1;
					end
					pci_pkg::CMD_H_ABS, pci_pkg::CMD_H_REL: begin
						ex_d = rel ? pci_pkg::sat_add(cur_x_q, value_s1) : value_s1;
					end
					pci_pkg::CMD_V_ABS, pci_pkg::CMD_V_REL: begin
						ey_d = rel ? pci_pkg::sat_add(cur_y_q, value_s1) : value_s1;
					end
					default: begin
						kind_d = pci_pkg::SEG_CUBIC;
						c1x_d  = rel ? pci_pkg::sat_add(cur_x_q, op_store_q[0]) : op_store_q[0];
						c1y_d  = rel ? pci_pkg::sat_add(cur_y_q, op_store_q[1]) : op_store_q[1];
						c2x_d  = rel ? pci_pkg::sat_add(cur_x_q, op_store_q[2]) : op_store_q[2];
						c2y_d  = rel ? pci_pkg::sat_add(cur_y_q, op_store_q[3]) : op_store_q[3];
						ex_d   = rel ? pci_pkg::sat_add(cur_x_q, op_store_q[4]) : op_store_q[4];
						ey_d   = rel ? pci_pkg::sat_add(cur_y_q, value_s1) : value_s1;
					end
				endcase
				cur_x_d = ex_d;
				cur_y_d = ey_d;
			end
		end
	end

	// A token that emits waits only for room in the output register.
	assign do_proc   = valid_s1 && (!emit || !seg_valid_q || seg.ready);
	assign tok.ready = !valid_s1 || do_proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (tok.valid && tok.ready) || (valid_s1 && !do_proc);
		end
	end

	always_ff @(posedge clk) begin
		if (tok.valid && tok.ready) begin
			kind_s1   <= tok.kind;
			letter_s1 <= tok.letter;
			value_s1  <= tok.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cmd_q <= pci_pkg::CMD_NONE;
			op_cnt_q     <= '0;
			skip_q       <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
		end else if (do_proc) begin
			active_cmd_q <= cmd_d;
			op_cnt_q     <= cnt_d;
			skip_q       <= skip_d;
			cur_x_q      <= cur_x_d;
			cur_y_q      <= cur_y_d;
			start_x_q    <= start_x_d;
			start_y_q    <= start_y_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_proc && wr_en) begin
			op_store_q[cnt_eff] <= value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
		end else if (do_proc && emit) begin
			seg_valid_q <= 1'b1;
		end else if (seg.ready) begin
			seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_proc && emit) begin
			seg_kind_q <= kind_d;
			from_x_q   <= cur_x_q;
			from_y_q   <= cur_y_q;
			c1x_q      <= c1x_d;
			c1y_q      <= c1y_d;
			c2x_q      <= c2x_d;
			c2y_q      <= c2y_d;
			end_x_q    <= ex_d;
			end_y_q    <= ey_d;
		end
	end

	assign seg.valid    = seg_valid_q;
	assign seg.seg_kind = seg_kind_q;
	assign seg.from_x   = from_x_q;
	assign seg.from_y   = from_y_q;
	assign seg.ctrl1_x  = c1x_q;
	assign seg.ctrl1_y  = c1y_q;
	assign seg.ctrl2_x  = c2x_q;
	assign seg.ctrl2_y  = c2y_q;
	assign seg.end_x    = end_x_q;
	assign seg.end_y    = end_y_q;

endmodule

/* sim/tb_path_command_interpreter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path command interpreter testbench
// Sends letter and number tokens through the token channel. A short directed
// list comes first, then random command sequences with noise mixed in. The
// testbench keeps its own copy of the pen position, figure start and operand
// buffer, and works out the segment that each token should produce. Every
// segment taken from the output channel is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_path_command_interpreter;

	import pci_pkg::*;

	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     RANDOM_TOKENS  = 600;
	localparam coord_t COORD_MAX      = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN      = 32'sh8000_0000;
	localparam coord_t ONE            = 32'sh0001_0000;

	typedef struct {
		logic                kind;
		logic [LetterW-1:0]  letter;
		coord_t              value;
	} token_t;

	typedef struct {
		seg_kind_t kind;
		coord_t    from_x;
		coord_t    from_y;
		coord_t    ctrl1_x;
		coord_t    ctrl1_y;
		coord_t    ctrl2_x;
		coord_t    ctrl2_y;
		coord_t    end_x;
		coord_t    end_y;
	} segment_t;

	logic clk;
	logic arst_n;

	pci_tok_if tok ();
	pci_seg_if seg ();

	path_command_interpreter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.seg    (seg)
	);

	token_t   pending_tokens[$];
	segment_t expected_segments[$];
	token_t   next_token;
	token_t   taken_token;
	segment_t want;

	logic [LetterW-1:0] known_letters[12] = '{CMD_M_ABS, CMD_M_REL, CMD_L_ABS, CMD_L_REL,
		CMD_H_ABS, CMD_H_REL, CMD_V_ABS, CMD_V_REL, CMD_C_ABS, CMD_C_REL,
		CMD_Z_ABS, CMD_Z_REL};

	// Interpreter state as the testbench sees it.
	logic [LetterW-1:0] cmd_now    = CMD_NONE;
	int                 ops_taken  = 0;
	coord_t             op_buf[StoreN];
	bit                 drop_next  = 1'b0;
	coord_t             pen_x      = '0;
	coord_t             pen_y      = '0;
	coord_t             fig_x      = '0;
	coord_t             fig_y      = '0;

	int err_count    = 0;
	int tokens_taken = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	int idle_cycles  = 0;

	// No random idling while the receiver holds off or inside a fixed window.
	wire quiet = (tokens_taken >= 350 && tokens_taken < 470);

	function automatic int arity(input logic [LetterW-1:0] c);
		case (c)
			CMD_M_ABS, CMD_M_REL, CMD_L_ABS, CMD_L_REL: return 2;
			CMD_H_ABS, CMD_H_REL, CMD_V_ABS, CMD_V_REL: return 1;
			CMD_C_ABS, CMD_C_REL:                       return 6;
			default:                                    return 0;
		endcase
	endfunction

	function automatic coord_t clamp_add(input coord_t a, input coord_t b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > COORD_MAX) return COORD_MAX;
		if (s < COORD_MIN) return COORD_MIN;
		return coord_t'(s);
	endfunction

	// Works out the segment, if any, that one accepted token produces.
	task automatic interpret_token(input token_t t);
		coord_t op[6];
		coord_t cp[6];
		coord_t x;
		coord_t y;
		int     need;
		int     i;
		bit     rel;
		if (drop_next) begin
			drop_next = 1'b0;
			return;
		end
		if (t.kind == TOK_LETTER) begin
			cmd_now   = t.letter;
			ops_taken = 0;
			if (t.letter == CMD_Z_ABS || t.letter == CMD_Z_REL) begin
				expected_segments.push_back('{SEG_CLOSE, pen_x, pen_y, 0, 0, 0, 0, fig_x, fig_y});
				pen_x = fig_x;
				pen_y = fig_y;
			end else if (arity(t.letter) == 0) begin
				drop_next = 1'b1;
			end
			return;
		end
		need = arity(cmd_now);
		if (need == 0)
			return;
		if (ops_taken >= need)
			ops_taken = 0;
		if (ops_taken + 1 < need) begin
			op_buf[ops_taken] = t.value;
			ops_taken++;
			return;
		end
		for (i = 0; i < ops_taken; i++)
			op[i] = op_buf[i];
		op[ops_taken] = t.value;
		ops_taken = 0;
		rel = (cmd_now >= CMD_LOW_A) && (cmd_now <= CMD_LOW_Z);
		case (cmd_now)
			CMD_M_ABS, CMD_M_REL, CMD_L_ABS, CMD_L_REL: begin
				x = rel ? clamp_add(pen_x, op[0]) : op[0];
				y = rel ? clamp_add(pen_y, op[1]) : op[1];
				if (cmd_now == CMD_M_ABS || cmd_now == CMD_M_REL) begin
					expected_segments.push_back('{SEG_MOVE, pen_x, pen_y, 0, 0, 0, 0, x, y});
					fig_x   = x;
					fig_y   = y;
					// Further pairs after a move are lines.
					cmd_now = rel ? CMD_L_REL : CMD_L_ABS;
				end else begin
					expected_segments.push_back('{SEG_LINE, pen_x, pen_y, 0, 0, 0, 0, x, y});
				end
				pen_x = x;
				pen_y = y;
			end
			CMD_H_ABS, CMD_H_REL: begin
				x = rel ? clamp_add(pen_x, op[0]) : op[0];
				expected_segments.push_back('{SEG_LINE, pen_x, pen_y, 0, 0, 0, 0, x, pen_y});
				pen_x = x;
			end
			CMD_V_ABS, CMD_V_REL: begin
				y = rel ? clamp_add(pen_y, op[0]) : op[0];
				expected_segments.push_back('{SEG_LINE, pen_x, pen_y, 0, 0, 0, 0, pen_x, y});
				pen_y = y;
			end
			default: begin
				for (i = 0; i < 6; i++)
					cp[i] = rel ? clamp_add(i[0] ? pen_y : pen_x, op[i]) : op[i];
				expected_segments.push_back('{SEG_CUBIC, pen_x, pen_y, cp[0], cp[1],
					cp[2], cp[3], cp[4], cp[5]});
				pen_x = cp[4];
				pen_y = cp[5];
			end
		endcase
	endtask

	task automatic compare_field(input string name, input coord_t exp_v, input coord_t got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			err_count++;
		end
	endtask

	function automatic coord_t pick_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return coord_t'($urandom_range(0, 20 * 65536)) - coord_t'(10 * 65536);
		if (r < 55) return COORD_MAX - coord_t'($urandom_range(0, 4 * 65536));
		if (r < 65) return COORD_MIN + coord_t'($urandom_range(0, 4 * 65536));
		return coord_t'($urandom());
	endfunction

	// Letter words carry a random value and number words a random letter,
	// so the unused field toggles too.
	task automatic push_letter(input logic [LetterW-1:0] c);
		pending_tokens.push_back('{TOK_LETTER, c, coord_t'($urandom())});
	endtask

	task automatic push_number(input coord_t v);
		pending_tokens.push_back('{TOK_NUMBER, LetterW'($urandom_range(0, 255)), v});
	endtask

	task automatic wait_drained();
		while (pending_tokens.size() != 0 || tok.valid || expected_segments.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Token driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok.valid  <= 1'b0;
			tok.kind   <= TOK_LETTER;
			tok.letter <= CMD_NONE;
			tok.value  <= '0;
		end else if (!tok.valid || tok.ready) begin
			if (pending_tokens.size() != 0 &&
					(quiet || hold_left != 0 || $urandom_range(0, 99) >= 18)) begin
				next_token = pending_tokens.pop_front();
				tok.valid  <= 1'b1;
				tok.kind   <= next_token.kind;
				tok.letter <= next_token.letter;
				tok.value  <= next_token.value;
			end else begin
				tok.valid <= 1'b0;
			end
		end
	end

	// One long receiver hold-off partway through, so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && tokens_taken >= 200) begin
			hold_left <= 120;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg.ready <= 1'b0;
		end else begin
			seg.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 18);
		end
	end

	// Monitor: predicts on each accepted token and checks each accepted segment.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok.valid && tok.ready) begin
				taken_token = '{tok.kind, tok.letter, tok.value};
				interpret_token(taken_token);
				tokens_taken <= tokens_taken + 1;
			end
			if (seg.valid && seg.ready) begin
				if (expected_segments.size() == 0) begin
					$error("segment word arrived with none expected (kind %0d)", seg.seg_kind);
					err_count++;
				end else begin
					want = expected_segments.pop_front();
					compare_field("seg_kind", coord_t'(want.kind), coord_t'(seg.seg_kind));
					compare_field("from_x", want.from_x, seg.from_x);
					compare_field("from_y", want.from_y, seg.from_y);
					compare_field("ctrl1_x", want.ctrl1_x, seg.ctrl1_x);
					compare_field("ctrl1_y", want.ctrl1_y, seg.ctrl1_y);
					compare_field("ctrl2_x", want.ctrl2_x, seg.ctrl2_x);
					compare_field("ctrl2_y", want.ctrl2_y, seg.ctrl2_y);
					compare_field("end_x", want.end_x, seg.end_x);
					compare_field("end_y", want.end_y, seg.end_y);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tok.valid && tok.ready) || (seg.valid && seg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		int          reps;
		int          n;
		int          i;
		logic [LetterW-1:0] c;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A number before any command is dropped.
		push_number(5 * ONE);
		// Absolute move to the extremes, then an implicit line.
		push_letter(CMD_M_ABS);
		push_number(COORD_MAX);
		push_number(COORD_MIN);
		push_number(COORD_MAX);
		push_number(COORD_MIN);
		// Relative line that saturates both ways, then relative H and absolute V.
		push_letter(CMD_L_REL);
		push_number(COORD_MAX);
		push_number(COORD_MIN);
		push_letter(CMD_H_REL);
		push_number(ONE);
		push_letter(CMD_V_ABS);
		push_number('0);
		// A new letter while an operand is pending drops the partial pair.
		push_letter(CMD_L_ABS);
		push_number(7 * ONE);
		push_letter(CMD_C_REL);
		for (i = 0; i < 6; i++)
			push_number(coord_t'(i + 1) * ONE);
		push_letter(CMD_Z_ABS);
		push_number(3 * ONE);
		// An unknown code swallows the next word, even a letter.
		push_letter(CMD_NONE);
		push_letter(CMD_L_ABS);
		push_number(ONE);
		push_letter(8'hFF);
		push_number(ONE);
		push_letter(CMD_Z_REL);
		wait_drained();

		while (pending_tokens.size() < RANDOM_TOKENS) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				c = known_letters[$urandom_range(0, 11)];
				push_letter(c);
				reps = $urandom_range(1, 3);
				for (i = 0; i < reps * arity(c); i++)
					push_number(pick_coord());
			end else if (r < 90) begin
				push_letter(LetterW'($urandom_range(0, 255)));
				n = $urandom_range(0, 2);
				for (i = 0; i < n; i++)
					push_number(pick_coord());
			end else begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					push_number(pick_coord());
			end
		end
		wait_drained();
		repeat (8) @(posedge clk);

		if (err_count == 0 && expected_segments.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
